/* rtl/crq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command retransmit queue package
// Shared types, codes and reset constants for the command retransmit queue.
// ----------------------------------------------------------------------------
package crq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int CODE_MATCH_W    = 4;

    localparam logic [7:0] RESEND_PERIOD_RST = 8'd3;
    localparam logic [7:0] RETRY_LIMIT_RST   = 8'd5;
    localparam logic [7:0] RESEND_MAX        = 8'hff;

    // event kinds
    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_ACK  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // error report codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_COMM    = 2'd1;
    localparam logic [1:0] ERR_RECOVER = 2'd2;

    // configuration register indexes
    localparam logic CFG_RESEND_PERIOD = 1'b0;
    localparam logic CFG_RETRY_LIMIT   = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  cmd_type;
        logic [31:0] cmd_code;
        logic [31:0] cmd_arg;
    } cmd_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_type;
        logic [31:0] tx_code;
        logic [31:0] tx_arg;
        logic [1:0]  error_report;
        logic        queue_overflow;
        logic [3:0]  queue_level;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  cmd_type;
        logic [31:0] cmd_code;
        logic [31:0] cmd_arg;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/crq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command retransmit queue cell
// One pending command slot; shifts toward the head on a pop, loads on a push.
// ----------------------------------------------------------------------------
module crq_cell
(
    input  wire                  clk,
    input  crq_pkg::cell_ctrl_t  ctrl,
    input  crq_pkg::entry_t      neighbor,
    input  crq_pkg::entry_t      fresh,
    output crq_pkg::entry_t      entry
);

    crq_pkg::entry_t entry_reg;
    crq_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = neighbor;
        end
        else if (ctrl.load)
        begin
            entry_next = fresh;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

/* rtl/command_retransmit_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command retransmit queue
// Stop-and-wait pending-command queue with timed resend of the head command.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one event per
//   transaction: send, reply received or timer tick. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one result per event.
//   Pending commands sit in a row of QUEUE_DEPTH cells with the head in
//   cell 0; a pop shifts every cell one place toward the head, a push
//   loads the first free cell.
//   The result is registered at the edge that takes the event. Throughput
//   is one event per cycle while rsp_stall is low, set by the state update
//   and the one-entry result register.
//   While a result waits under rsp_stall, cmd_stall is raised; the result
//   register holds its value until taken.
//   Reset clears the counters, the error flag and the result valid flag, and
//   loads resend_period = 3 and retry_limit = 5. Slot contents are not
//   cleared; the fill count alone tells which slots hold commands.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// ----------------------------------------------------------------------------
module command_retransmit_queue_unit
#(
    parameter int QUEUE_DEPTH = crq_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cmd_valid,
    output logic             cmd_stall,
    input  crq_pkg::cmd_t    cmd,
    output logic             rsp_valid,
    input  wire              rsp_stall,
    output crq_pkg::rsp_t    rsp,
    input  wire              cfg_we,
    input  wire              cfg_index,
    input  wire  [7:0]       cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       tick_reg;
    logic [7:0]       tick_next;
    logic [7:0]       resend_reg;
    logic [7:0]       resend_next;
    logic             err_raised_reg;
    logic             err_raised_next;
    logic [7:0]       period_reg;
    logic [7:0]       limit_reg;
    logic             rsp_valid_reg;
    crq_pkg::rsp_t    rsp_reg;

    crq_pkg::rsp_t    result;
    crq_pkg::entry_t  fresh;
    crq_pkg::entry_t  cell_q [QUEUE_DEPTH];
    logic             accept;
    logic             push;
    logic             pop;
    logic [8:0]       tick_inc;
    logic [7:0]       resend_inc;
    logic [CNT_W+3:0] level_ext;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = rsp_valid_reg && rsp_stall;

    assign fresh.cmd_type = cmd.cmd_type;
    assign fresh.cmd_code = cmd.cmd_code;
    assign fresh.cmd_arg  = cmd.cmd_arg;

    assign tick_inc   = {1'b0, tick_reg} + 9'd1;
    assign resend_inc = (resend_reg != crq_pkg::RESEND_MAX) ? resend_reg + 8'd1 : resend_reg;
    assign level_ext  = {4'b0000, count_next};

    // event decode and state update
    always_comb
    begin
        count_next      = count_reg;
        tick_next       = tick_reg;
        resend_next     = resend_reg;
        err_raised_next = err_raised_reg;
        push            = 1'b0;
        pop             = 1'b0;
        result          = '0;

        if (accept)
        begin
            case (cmd.mode)
                crq_pkg::MODE_SEND:
                begin
                    result.tx_valid = 1'b1;
                    result.tx_type  = cmd.cmd_type;
                    result.tx_code  = cmd.cmd_code;
                    result.tx_arg   = cmd.cmd_arg;
                    if (count_reg != CNT_W'(QUEUE_DEPTH))
                    begin
                        push       = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result.queue_overflow = 1'b1;
                    end
                end
                crq_pkg::MODE_ACK:
                begin
                    if (count_reg != '0)
                    begin
                        // masked reply code against the full head code
                        if (cell_q[0].cmd_code[31:crq_pkg::CODE_MATCH_W] == '0 &&
                            cell_q[0].cmd_code[crq_pkg::CODE_MATCH_W-1:0] ==
                            cmd.cmd_code[crq_pkg::CODE_MATCH_W-1:0])
                        begin
                            pop        = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                        if (count_next == '0)
                        begin
                            tick_next   = '0;
                            resend_next = '0;
                        end
                    end
                end
                crq_pkg::MODE_TICK:
                begin
                    if (count_reg != '0)
                    begin
                        if (tick_inc > {1'b0, period_reg})
                        begin
                            tick_next       = '0;
                            result.tx_valid = 1'b1;
                            result.tx_type  = cell_q[0].cmd_type;
                            result.tx_code  = cell_q[0].cmd_code;
                            result.tx_arg   = cell_q[0].cmd_arg;
                            resend_next     = resend_inc;
                            if (resend_inc > limit_reg)
                            begin
                                err_raised_next     = 1'b1;
                                result.error_report = crq_pkg::ERR_COMM;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc[7:0];
                        end
                    end
                    else
                    begin
                        tick_next   = '0;
                        resend_next = '0;
                        if (err_raised_reg)
                        begin
                            err_raised_next     = 1'b0;
                            result.error_report = crq_pkg::ERR_RECOVER;
                        end
                    end
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end

        result.queue_level = level_ext[3:0];
    end

    // row of slots, head in cell 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        crq_pkg::cell_ctrl_t ctrl;
        crq_pkg::entry_t     neighbor;

        assign ctrl.shift = pop;
        assign ctrl.load  = push && (count_reg == CNT_W'(i));

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign neighbor = cell_q[i];
        end
        else
        begin : g_body
            assign neighbor = cell_q[i + 1];
        end

        crq_cell u_cell
        (
            .clk      (clk),
            .ctrl     (ctrl),
            .neighbor (neighbor),
            .fresh    (fresh),
            .entry    (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            tick_reg       <= '0;
            resend_reg     <= '0;
            err_raised_reg <= 1'b0;
            period_reg     <= crq_pkg::RESEND_PERIOD_RST;
            limit_reg      <= crq_pkg::RETRY_LIMIT_RST;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            tick_reg       <= tick_next;
            resend_reg     <= resend_next;
            err_raised_reg <= err_raised_next;
            if (cfg_we)
            begin
                if (cfg_index == crq_pkg::CFG_RESEND_PERIOD)
                begin
                    period_reg <= cfg_data;
                end
                else
                begin
                    limit_reg <= cfg_data;
                end
            end
            // hold the result until taken
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count exceeds queue depth");

    a_full_send_keeps : assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.mode == crq_pkg::MODE_SEND && count_reg == CNT_W'(QUEUE_DEPTH)
        |=> count_reg == CNT_W'(QUEUE_DEPTH) && rsp.queue_overflow)
        else $error("send on full queue changed the fill count");

    a_comm_err_resends : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error_report == crq_pkg::ERR_COMM |-> rsp.tx_valid)
        else $error("communication error reported without a resend");

    a_idle_tick_clears : assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.mode == crq_pkg::MODE_TICK && count_reg == '0
        |=> tick_reg == '0 && resend_reg == '0 && !err_raised_reg)
        else $error("tick on empty queue left counters or error flag set");

endmodule
`default_nettype wire

/* dv/command_retransmit_queue_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command retransmit queue testbench
// Sends send, reply and tick events and checks each result against a
// scoreboard of pending commands, tick and resend counters and the error
// flag. Covers queue overflow, timed resend, error and recovery reports,
// the extreme register values, output backpressure and random traffic.
// ----------------------------------------------------------------------------
module command_retransmit_queue_unit_tb;

    localparam int         DEPTH       = crq_pkg::QUEUE_DEPTH_DEF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cmd_valid = 1'b0;
    crq_pkg::cmd_t   cmd       = '0;
    logic            rsp_stall = 1'b0;
    logic            cfg_we    = 1'b0;
    logic            cfg_index = crq_pkg::CFG_RESEND_PERIOD;
    logic [7:0]      cfg_data  = '0;
    logic            cmd_stall;
    logic            rsp_valid;
    crq_pkg::rsp_t   rsp;

    // scoreboard state
    crq_pkg::entry_t pending_q[$];
    logic [7:0]      tick_cnt    = '0;
    logic [7:0]      resend_cnt  = '0;
    logic            err_flag    = 1'b0;
    logic [7:0]      period_q    = crq_pkg::RESEND_PERIOD_RST;
    logic [7:0]      limit_q     = crq_pkg::RETRY_LIMIT_RST;
    crq_pkg::rsp_t   rsp_due[$];

    int send_idle_pct  = 25;
    int recv_stall_pct = 69;
    int hold_req       = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int rsp_seen       = 0;

    command_retransmit_queue_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Apply one event to the scoreboard and return the result it causes.
    function automatic crq_pkg::rsp_t event_result(input crq_pkg::cmd_t c);
        crq_pkg::rsp_t   r;
        crq_pkg::entry_t e;
        logic [8:0]      ticks;
        r = '0;
        case (c.mode)
            crq_pkg::MODE_SEND:
            begin
                r.tx_valid = 1'b1;
                r.tx_type  = c.cmd_type;
                r.tx_code  = c.cmd_code;
                r.tx_arg   = c.cmd_arg;
                if (pending_q.size() < DEPTH)
                begin
                    e.cmd_type = c.cmd_type;
                    e.cmd_code = c.cmd_code;
                    e.cmd_arg  = c.cmd_arg;
                    pending_q.push_back(e);
                end
                else
                begin
                    r.queue_overflow = 1'b1;
                end
            end
            crq_pkg::MODE_ACK:
            begin
                if (pending_q.size() != 0)
                begin
                    // masked reply against the full head code
                    if ({28'd0, c.cmd_code[3:0]} == pending_q[0].cmd_code)
                        pending_q.delete(0);
                    if (pending_q.size() == 0)
                    begin
                        tick_cnt   = '0;
                        resend_cnt = '0;
                    end
                end
            end
            crq_pkg::MODE_TICK:
            begin
                if (pending_q.size() != 0)
                begin
                    ticks = {1'b0, tick_cnt} + 9'd1;
                    if (ticks > {1'b0, period_q})
                    begin
                        tick_cnt   = '0;
                        r.tx_valid = 1'b1;
                        r.tx_type  = pending_q[0].cmd_type;
                        r.tx_code  = pending_q[0].cmd_code;
                        r.tx_arg   = pending_q[0].cmd_arg;
                        if (resend_cnt != crq_pkg::RESEND_MAX)
                            resend_cnt = resend_cnt + 8'd1;
                        if (resend_cnt > limit_q)
                        begin
                            err_flag       = 1'b1;
                            r.error_report = crq_pkg::ERR_COMM;
                        end
                    end
                    else
                    begin
                        tick_cnt = ticks[7:0];
                    end
                end
                else
                begin
                    tick_cnt   = '0;
                    resend_cnt = '0;
                    if (err_flag)
                    begin
                        err_flag       = 1'b0;
                        r.error_report = crq_pkg::ERR_RECOVER;
                    end
                end
            end
            default: ;
        endcase
        r.queue_level = 4'(pending_q.size());
        return r;
    endfunction

    function automatic crq_pkg::cmd_t pack_event(input logic [1:0] mode, input logic [7:0] typ,
                                                 input logic [31:0] code,
                                                 input logic [31:0] arg);
        crq_pkg::cmd_t c;
        c.mode     = mode;
        c.cmd_type = typ;
        c.cmd_code = code;
        c.cmd_arg  = arg;
        return c;
    endfunction

    // Reply whose low nibble matches the current head, random upper bits.
    function automatic crq_pkg::cmd_t matching_ack();
        crq_pkg::cmd_t c;
        c = pack_event(crq_pkg::MODE_ACK, 8'($urandom), $urandom, $urandom);
        if (pending_q.size() != 0)
            c.cmd_code[3:0] = pending_q[0].cmd_code[3:0];
        return c;
    endfunction

    // Mostly well-formed traffic: small codes so replies can pop the head.
    // Sends into a full queue and wide_codes mode use the full code range.
    function automatic crq_pkg::cmd_t random_event(input bit wide_codes);
        crq_pkg::cmd_t c;
        int unsigned   pick;
        c    = pack_event(crq_pkg::MODE_TICK, 8'($urandom), $urandom, $urandom);
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            c.mode = crq_pkg::MODE_SEND;
            if (!wide_codes && pending_q.size() < DEPTH)
                c.cmd_code = $urandom_range(15);
        end
        else if (pick < 55)
        begin
            if ($urandom_range(9) < 7)
                c = matching_ack();
            else
                c.mode = crq_pkg::MODE_ACK;
        end
        else if (pick >= 96)
        begin
            c.mode = MODE_UNUSED;
        end
        return c;
    endfunction

    task automatic send_event(input crq_pkg::cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        rsp_due.push_back(event_result(c));
    endtask

    // Hold off the sender until every expected result has been taken.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] period, input logic [7:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= crq_pkg::CFG_RESEND_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        cfg_index <= crq_pkg::CFG_RETRY_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        period_q = period;
        limit_q  = limit;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected %h, got %h", rsp_seen, what, want, got);
        end
    endtask

    task automatic check_result(input crq_pkg::rsp_t got);
        crq_pkg::rsp_t want;
        rsp_seen++;
        if (rsp_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with none expected: %h", rsp_seen, got);
        end
        else
        begin
            want = rsp_due.pop_front();
            check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
            check_field("tx_type", 32'(want.tx_type), 32'(got.tx_type));
            check_field("tx_code", want.tx_code, got.tx_code);
            check_field("tx_arg", want.tx_arg, got.tx_arg);
            check_field("error_report", 32'(want.error_report), 32'(got.error_report));
            check_field("queue_overflow", 32'(want.queue_overflow),
                        32'(got.queue_overflow));
            check_field("queue_level", 32'(want.queue_level), 32'(got.queue_level));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_result(rsp);
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic test_directed_cases();
        int k;
        send_event(pack_event(crq_pkg::MODE_TICK, 8'h00, 32'h0, 32'h0));
        send_event(pack_event(crq_pkg::MODE_ACK, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
        send_event(pack_event(MODE_UNUSED, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
        send_event(pack_event(crq_pkg::MODE_SEND, 8'hff, 32'h0, 32'hffff_ffff));
        // wrong nibble keeps the head, right nibble drains the queue
        send_event(pack_event(crq_pkg::MODE_ACK, 8'h00, 32'hffff_fff1, 32'h0));
        send_event(pack_event(crq_pkg::MODE_ACK, 8'h00, 32'hffff_fff0, 32'h0));
        for (k = 0; k < DEPTH; k++)
            send_event(pack_event(crq_pkg::MODE_SEND, 8'(k * 37), 32'(k + 1), $urandom));
        // full queue: transmitted but not stored
        send_event(pack_event(crq_pkg::MODE_SEND, 8'h5a, 32'hffff_ffff, 32'h0));
        repeat (4) send_event(pack_event(crq_pkg::MODE_TICK, 8'h00, 32'h0, 32'h0));
        wait_drained();
        write_config(8'd0, 8'd1);
        repeat (2) send_event(pack_event(crq_pkg::MODE_TICK, 8'h00, 32'h0, 32'h0));
        for (k = 0; k < DEPTH; k++)
            send_event(matching_ack());
        send_event(pack_event(crq_pkg::MODE_TICK, 8'h00, 32'h0, 32'h0));
    endtask

    task automatic test_long_period();
        wait_drained();
        write_config(8'd255, 8'd255);
        send_event(pack_event(crq_pkg::MODE_SEND, 8'h3c, 32'hc, 32'h1234_5678));
        repeat (257) send_event(pack_event(crq_pkg::MODE_TICK, 8'h00, 32'h0, 32'h0));
        send_event(matching_ack());
        send_event(pack_event(crq_pkg::MODE_TICK, 8'h00, 32'h0, 32'h0));
    endtask

    // Resend count must stick at its maximum, so errors keep coming.
    task automatic test_resend_saturation();
        wait_drained();
        write_config(8'd0, 8'd254);
        send_event(pack_event(crq_pkg::MODE_SEND, 8'hc3, 32'h5, 32'h8765_4321));
        repeat (260) send_event(pack_event(crq_pkg::MODE_TICK, 8'h00, 32'h0, 32'h0));
        send_event(matching_ack());
        send_event(pack_event(crq_pkg::MODE_TICK, 8'h00, 32'h0, 32'h0));
    endtask

    task automatic test_output_backpressure();
        int k;
        wait_drained();
        write_config(8'd1, 8'd3);
        send_idle_pct = 0;
        hold_req      = 300;
        for (k = 0; k < 40; k++)
            send_event(random_event(1'b0));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [7:0] periods [6];
        logic [7:0] limits  [6];
        int         phase;
        int         seg;
        int         idx;
        int         k;
        periods = '{8'd3, 8'd0, 8'd1, 8'd255, 8'd0, 8'd2};
        limits  = '{8'd5, 8'd0, 8'd2, 8'd0, 8'd255, 8'd9};
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 69 : 0;
            recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 25 : 0;
            for (seg = 0; seg < 4; seg++)
            begin
                idx = (phase * 4 + seg) % 6;
                wait_drained();
                if (idx == 5)
                    write_config(8'($urandom_range(6)), 8'($urandom_range(255)));
                else
                    write_config(periods[idx], limits[idx]);
                for (k = 0; k < 36; k++)
                begin
                    if ($urandom_range(99) < 2)
                        wait_drained();
                    send_event(random_event(1'b0));
                end
            end
        end
    endtask

    // Full-range codes: a head above 15 can never be popped, so run last.
    task automatic test_unmatchable_head();
        int k;
        wait_drained();
        write_config(8'($urandom_range(3)), 8'($urandom_range(4)));
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        for (k = 0; k < 80; k++)
            send_event(random_event(1'b1));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_long_period();
        test_resend_saturation();
        test_output_backpressure();
        test_random_traffic();
        test_unmatchable_head();
        wait_drained();
        if (mismatches == 0 && rsp_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
